// ----- hdl/mhpq_pkg.sv -----
// Shared types, constants and command codes for the max-heap priority queue.
package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 11;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] STS_OK         = 2'd0;
	localparam logic [1:0] STS_PUSH_FULL  = 2'd1;
	localparam logic [1:0] STS_POP_EMPTY  = 2'd2;

	typedef struct packed {
		logic                     operation;
		logic signed [DATA_W-1:0] value;
	} req_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [OUT_CNT_W-1:0]     entry_count;
		logic                     is_empty;
		logic [1:0]               status;
	} rsp_word_t;

	// datapath commands issued by the controller
	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_ACCEPT,
		CMD_RD_PARENT,
		CMD_WR_MOVING,
		CMD_WR_PARENT,
		CMD_TAKE_LAST,
		CMD_RD_LEFT,
		CMD_RD_RIGHT,
		CMD_WR_PICK,
		CMD_LOAD_OUT
	} mhpq_cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic push_ok;
		logic pop_ok;
		logic slot_zero;
		logic parent_ge;
		logic child_oob;
		logic moving_ge;
	} mhpq_sts_t;

endpackage

// ----- hdl/mhpq_ram.sv -----
// Generic single-port RAM with registered read data.
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                            wdata,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- hdl/mhpq_datapath.sv -----
// Heap datapath: fill count, sift registers, heap store and result register.
module mhpq_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mhpq_pkg::mhpq_cmd_t cmd,
	input  mhpq_pkg::req_word_t req,
	output mhpq_pkg::mhpq_sts_t sts,
	output mhpq_pkg::rsp_word_t rsp
);
	import mhpq_pkg::*;

	localparam int IDX_W = ADDR_W + 2;

	logic [CNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]        slot_q;
	logic signed [DATA_W-1:0] moving_q;
	logic signed [DATA_W-1:0] left_q;
	logic signed [DATA_W-1:0] top_q;
	logic [1:0]               status_q;
	rsp_word_t                rsp_q;

	logic                     ram_en;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_addr;
	logic [DATA_W-1:0]        ram_wdata;
	logic [DATA_W-1:0]        ram_rdata;
	logic signed [DATA_W-1:0] rd_data;

	logic              full;
	logic              empty;
	logic [ADDR_W-1:0] parent_addr;
	logic [ADDR_W-1:0] last_addr;
	logic [IDX_W-1:0]  count_x;
	logic [IDX_W-1:0]  child_x;
	logic [IDX_W-1:0]  right_x;
	logic              right_ok;
	logic              take_right;
	logic signed [DATA_W-1:0] pick_val;
	logic [ADDR_W-1:0] pick_idx;
	logic [1:0]        status_code;

	assign rd_data     = $signed(ram_rdata);
	assign full        = (count_q == CNT_W'(CAPACITY));
	assign empty       = (count_q == '0);
	assign parent_addr = (slot_q - ADDR_W'(1)) >> 1;
	assign last_addr   = ADDR_W'(count_q - CNT_W'(1));
	assign count_x     = IDX_W'(count_q);
	assign child_x     = {1'b0, slot_q, 1'b1};
	assign right_x     = child_x + IDX_W'(1);
	assign right_ok    = (right_x < count_x);
	// right child wins ties
	assign take_right  = right_ok && (rd_data >= left_q);
	assign pick_val    = take_right ? rd_data : left_q;
	assign pick_idx    = take_right ? right_x[ADDR_W-1:0] : child_x[ADDR_W-1:0];

	always_comb begin
		priority if (req.operation == OP_PUSH && full) begin
			status_code = STS_PUSH_FULL;
		end else if (req.operation == OP_POP && empty) begin
			status_code = STS_POP_EMPTY;
		end else begin
			status_code = STS_OK;
		end
	end

	assign sts.push_ok   = (req.operation == OP_PUSH) && !full;
	assign sts.pop_ok    = (req.operation == OP_POP) && !empty;
	assign sts.slot_zero = (slot_q == '0);
	assign sts.parent_ge = (rd_data >= moving_q);
	assign sts.child_oob = (child_x >= count_x);
	assign sts.moving_ge = (moving_q >= pick_val);

	// memory port steering
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = slot_q;
		ram_wdata = moving_q;
		unique case (cmd)
			CMD_ACCEPT: begin
				if (sts.pop_ok) begin
					ram_en   = 1'b1;
					ram_addr = last_addr;
				end
			end
			CMD_RD_PARENT: begin
				ram_en   = 1'b1;
				ram_addr = parent_addr;
			end
			CMD_WR_MOVING: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			CMD_WR_PARENT: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = rd_data;
			end
			CMD_RD_LEFT: begin
				ram_en   = 1'b1;
				ram_addr = child_x[ADDR_W-1:0];
			end
			CMD_RD_RIGHT: begin
				ram_en   = 1'b1;
				ram_addr = right_x[ADDR_W-1:0];
			end
			CMD_WR_PICK: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = pick_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd == CMD_ACCEPT) begin
			if (sts.push_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (sts.pop_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		// shadow of slot 0 so the top needs no extra read
		if (ram_we && ram_addr == '0) begin
			top_q <= ram_wdata;
		end
		unique case (cmd)
			CMD_ACCEPT: begin
				status_q <= status_code;
				if (sts.push_ok) begin
					slot_q   <= ADDR_W'(count_q);
					moving_q <= req.value;
				end else if (sts.pop_ok) begin
					slot_q <= '0;
				end
			end
			CMD_TAKE_LAST: moving_q <= rd_data;
			CMD_WR_PARENT: slot_q   <= parent_addr;
			CMD_RD_RIGHT:  left_q   <= rd_data;
			CMD_WR_PICK:   slot_q   <= pick_idx;
			CMD_LOAD_OUT: begin
				rsp_q.top_value   <= empty ? '0 : top_q;
				rsp_q.entry_count <= OUT_CNT_W'(count_q);
				rsp_q.is_empty    <= empty;
				rsp_q.status      <= status_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp = rsp_q;

	mhpq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

// ----- hdl/mhpq_ctrl.sv -----
// Heap controller: sequences sift-up and sift-down over the single memory port.
module mhpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  mhpq_pkg::mhpq_sts_t sts,
	output mhpq_pkg::mhpq_cmd_t cmd
);
	import mhpq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_UP,
		ST_PUSH_CMP,
		ST_POP_TAKE,
		ST_POP_LEFT,
		ST_POP_RIGHT,
		ST_POP_PICK,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						priority if (sts.push_ok) begin
							state_q <= ST_PUSH_UP;
						end else if (sts.pop_ok) begin
							state_q <= ST_POP_TAKE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_PUSH_UP:   state_q <= sts.slot_zero ? ST_DONE : ST_PUSH_CMP;
				ST_PUSH_CMP:  state_q <= sts.parent_ge ? ST_DONE : ST_PUSH_UP;
				ST_POP_TAKE:  state_q <= ST_POP_LEFT;
				ST_POP_LEFT:  state_q <= sts.child_oob ? ST_DONE : ST_POP_RIGHT;
				ST_POP_RIGHT: state_q <= ST_POP_PICK;
				ST_POP_PICK:  state_q <= sts.moving_ge ? ST_DONE : ST_POP_LEFT;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:      cmd = req_valid ? CMD_ACCEPT : CMD_NOP;
			ST_PUSH_UP:   cmd = sts.slot_zero ? CMD_WR_MOVING : CMD_RD_PARENT;
			ST_PUSH_CMP:  cmd = sts.parent_ge ? CMD_WR_MOVING : CMD_WR_PARENT;
			ST_POP_TAKE:  cmd = CMD_TAKE_LAST;
			ST_POP_LEFT:  cmd = sts.child_oob ? CMD_WR_MOVING : CMD_RD_LEFT;
			ST_POP_RIGHT: cmd = CMD_RD_RIGHT;
			ST_POP_PICK:  cmd = sts.moving_ge ? CMD_WR_MOVING : CMD_WR_PICK;
			ST_DONE:      cmd = out_free ? CMD_LOAD_OUT : CMD_NOP;
			default:      cmd = CMD_NOP;
		endcase
	end

endmodule

// ----- hdl/max_heap_priority_queue.sv -----
// Binary max-heap priority queue of signed 32-bit words, 1024 entries deep.
// A request word either pushes a value (operation 0) or pops the maximum
// (operation 1); every request yields exactly one response word carrying
// the new top value (zero when empty), the entry count, an empty flag and a
// status code (ok, push refused because full, pop refused because empty).
// Refused requests leave the heap untouched. One request is in flight at a
// time: req_ready is high only while the sequencer is idle, and a finished
// response waits in an output register so the next request can be taken
// while the response is still unclaimed. All heap traffic goes through one
// single-port RAM with registered read, so the memory port sets the pace.
// A push reads the parent and writes one slot for each level that the value
// climbs. A pop moves the last entry to the root and sinks it, each level
// reading both children and writing one slot. A response still unclaimed
// when the next one is ready holds the sequencer for as long as it waits.
// The heap store needs no clearing after reset: only slots below the fill
// count are ever used, and a right-child read beyond it is ignored.
module max_heap_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mhpq_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mhpq_pkg::rsp_word_t rsp
);
	import mhpq_pkg::*;

	mhpq_cmd_t cmd;   // controller -> datapath
	mhpq_sts_t sts;   // datapath -> controller

	// sequencer: walks the heap at most one memory access per cycle, holding while a response waits
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage, compares and the response register
	mhpq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// ----- hdl/mhpq_checker.sv -----
// Port-level checks for the max-heap priority queue, bound to the top level.
module mhpq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input mhpq_pkg::req_word_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input mhpq_pkg::rsp_word_t rsp
);
	import mhpq_pkg::*;

	// one request at a time: ready drops right after an accept
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// an empty heap reports zero as its top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.top_value == '0)
		else $error("empty heap reports nonzero top");

	// a refused pop only happens on an empty heap
	a_pop_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_POP_EMPTY |-> rsp.is_empty)
		else $error("pop refused on non-empty heap");

	// a refused push reports a full heap
	a_push_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_PUSH_FULL |->
			rsp.entry_count == OUT_CNT_W'(CAPACITY))
		else $error("push refused on heap that is not full");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

// ----- tb/sv/max_heap_priority_queue_test.sv -----
// Self-checking testbench for the max-heap priority queue against a heap tracker.
module max_heap_priority_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mhpq_pkg::*;

	// The limit leaves a wide margin over about 2000 words at full-depth pop cost,
	// with random idle gaps on each side of every word.
	localparam int CYCLE_LIMIT   = 600000;
	// The block holds one request at a time, so this settle covers any straggler.
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_LIMIT  = 10;

	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Mirrors the heap contents and queues the response word each accepted request
	// should produce. Responses come back in request order, so one FIFO is enough.
	class heap_tracker;
		logic signed [DATA_W-1:0] heap_copy [CAPACITY];
		int unsigned              fill_level;
		rsp_word_t                expected_rsp [$];
		int unsigned              mismatch_count;

		function new();
			fill_level     = 0;
			mismatch_count = 0;
		endfunction

		// new value climbs until it sits below a parent that is >= it
		function void sift_in_value(logic signed [DATA_W-1:0] v);
			int unsigned slot;
			int unsigned up;
			slot = fill_level;
			fill_level++;
			while (slot > 0) begin
				up = (slot - 1) >> 1;
				if (heap_copy[up] >= v)
					break;
				heap_copy[slot] = heap_copy[up];
				slot = up;
			end
			heap_copy[slot] = v;
		endfunction

		// last entry goes to the root and sinks; right child wins a tie
		function void remove_max();
			int unsigned              slot;
			int unsigned              child;
			logic signed [DATA_W-1:0] moving;
			bit                       done;
			fill_level--;
			moving = heap_copy[fill_level];
			slot   = 0;
			done   = 1'b0;
			while (!done) begin
				child = 2 * slot + 1;
				if (child >= fill_level) begin
					done = 1'b1;
				end else begin
					if (child + 1 < fill_level && heap_copy[child + 1] >= heap_copy[child])
						child = child + 1;
					if (moving >= heap_copy[child]) begin
						done = 1'b1;
					end else begin
						heap_copy[slot] = heap_copy[child];
						slot            = child;
					end
				end
			end
			heap_copy[slot] = moving;
		endfunction

		function void take_request(req_word_t w);
			rsp_word_t e;
			e.status = STS_OK;
			if (w.operation == OP_PUSH) begin
				if (fill_level >= CAPACITY)
					e.status = STS_PUSH_FULL;
				else
					sift_in_value(w.value);
			end else begin
				if (fill_level == 0)
					e.status = STS_POP_EMPTY;
				else
					remove_max();
			end
			e.top_value   = (fill_level != 0) ? heap_copy[0] : '0;
			e.entry_count = fill_level[OUT_CNT_W-1:0];
			e.is_empty    = (fill_level == 0);
			expected_rsp.push_back(e);
		endfunction

		function void check_response(rsp_word_t got);
			rsp_word_t e;
			if (expected_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected response: top %0d count %0d empty %0b status %0d",
						got.top_value, got.entry_count, got.is_empty, got.status);
				return;
			end
			e = expected_rsp.pop_front();
			if (got.top_value !== e.top_value || got.entry_count !== e.entry_count ||
					got.is_empty !== e.is_empty || got.status !== e.status) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("response mismatch: expected top %0d count %0d empty %0b status %0d",
						e.top_value, e.entry_count, e.is_empty, e.status);
					$display("                   got top %0d count %0d empty %0b status %0d",
						got.top_value, got.entry_count, got.is_empty, got.status);
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_rsp.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_word_t   req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_word_t   rsp;

	heap_tracker tracker;
	int unsigned cycle_count = 0;
	// when set, that side stops inserting idle cycles for a stretch of words
	bit          sender_calm   = 1'b0;
	bit          receiver_calm = 1'b0;

	max_heap_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("max_heap_priority_queue_test NOT OK");
			$finish;
		end
	end

	function automatic int unsigned draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// Value mix: full-range words for bit coverage, a narrow band so that
	// duplicates and ties show up often, values near both extremes, and
	// sign-extended shifts for a spread of magnitudes.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5:       return $signed($urandom_range(0, 15)) - 8;
			6:          return VAL_MAX - $urandom_range(0, 3);
			7:          return VAL_MIN + $urandom_range(0, 3);
			default:    return $signed($urandom()) >>> $urandom_range(0, 31);
		endcase
	endfunction

	// Present one request word after a random gap and hold it until it is taken.
	// If the gap is zero, valid stays high from the previous word. That avoids
	// two nonblocking writes to valid in one time step.
	task automatic send_word(req_word_t w);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			sender_calm = !sender_calm;
		gap = draw_wait(sender_calm);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (!(req_valid && req_ready));
		tracker.take_request(w);
	endtask

	task automatic push_word(logic signed [DATA_W-1:0] v);
		req_word_t w;
		w.operation = OP_PUSH;
		w.value     = v;
		send_word(w);
	endtask

	// value field is don't-care on a pop; keep it random anyway
	task automatic pop_word();
		req_word_t w;
		w.operation = OP_POP;
		w.value     = $urandom();
		send_word(w);
	endtask

	task automatic random_mix(int unsigned count, int unsigned push_pct);
		repeat (count) begin
			if ($urandom_range(1, 100) <= push_pct)
				push_word(pick_value());
			else
				pop_word();
		end
	endtask

	// drop valid so the last word is not taken twice, then wait for every response
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	// Response side: for each word, idle ready for a random number of cycles,
	// then hold it high until a response is taken, then check that response.
	initial begin
		int unsigned stall;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				receiver_calm = !receiver_calm;
			stall = draw_wait(receiver_calm);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			tracker.check_response(rsp);
		end
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pop on empty, one entry in and out, then extremes, ties and a drain
		pop_word();
		pop_word();
		push_word(VAL_MIN);
		pop_word();
		push_word('0);
		push_word(-1);
		push_word(VAL_MAX);
		push_word(VAL_MIN);
		push_word(1);
		push_word(5);
		push_word(5);
		push_word(5);
		push_word(VAL_MAX);
		// 9 entries are held now; the tenth pop hits an empty heap again
		repeat (10) pop_word();
		wait_drained();

		// mixed traffic around a shallow heap, visiting empty now and then
		random_mix(150, 55);
		wait_drained();

		// fill to capacity, so pops later sift through all ten levels
		while (tracker.fill_level < CAPACITY) begin
			if ($urandom_range(0, 19) == 0)
				pop_word();
			else
				push_word(pick_value());
		end
		// pushes to a full heap must be refused
		repeat (3) push_word(pick_value());
		// move around the full mark, then stop until every response has come back
		random_mix(40, 60);
		wait_drained();

		// deep pops from a nearly full heap
		random_mix(700, 10);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
			$display("max_heap_priority_queue_test OK");
		else
			$display("max_heap_priority_queue_test NOT OK");
		$finish;
	end

endmodule
